>>> rtl/core/ist_pkg.sv
// shared types and codes for the indexed sequence table
package ist_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned KindW  = 3;
  localparam int unsigned PosW   = 4;
  localparam int unsigned OutPosW = 5;
  localparam int unsigned OutCntW = 5;

  typedef enum logic [KindW-1:0] {
    KIND_APPEND = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_REMOVE = 3'd2,
    KIND_FIND   = 3'd3,
    KIND_GET    = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [PosW-1:0]         position;
    logic signed [WordW-1:0] value;
    logic [KindW-1:0]        kind;
  } req_t;

  typedef struct packed {
    logic [OutCntW-1:0]        count;
    logic signed [WordW-1:0]   read_value;
    logic signed [OutPosW-1:0] found_position;
    logic                      ok;
  } res_t;

endpackage

>>> rtl/core/ist_ram.sv
// element store: one write port, one registered read port
module ist_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                          clk_i,
  input  logic                          we_i,
  input  logic [AddrW-1:0]              waddr_i,
  input  logic [ist_pkg::WordW-1:0]     wdata_i,
  input  logic                          re_i,
  input  logic [AddrW-1:0]              raddr_i,
  output logic [ist_pkg::WordW-1:0]     rdata_o
);

  logic [ist_pkg::WordW-1:0] mem_q [Depth];
  logic [ist_pkg::WordW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/ist_seq.sv
// request sequencer: walks the store one entry a cycle with one compare unit
module ist_seq #(
  parameter int unsigned Capacity = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  input  ist_pkg::req_t req_i,
  output logic          res_valid_o,
  input  logic          res_ready_i,
  output ist_pkg::res_t res_o
);

  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CW = $clog2(Capacity + 1);
  localparam int unsigned XW = ((CW > ist_pkg::PosW) ? CW : ist_pkg::PosW) + 1;
  localparam logic [CW-1:0] OneC = CW'(1);

  ist_pkg::state_e state_q, state_d;
  ist_pkg::kind_e  kind_q, kind_d, req_kind;
  logic [ist_pkg::WordW-1:0] value_q, value_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] paddr_q, paddr_d;
  logic [CW-1:0] count_q, count_d;
  logic          issue_q, issue_d;
  logic          pend_q, pend_d;
  logic          ok_q, ok_d;
  logic [ist_pkg::OutPosW-1:0] found_q, found_d;
  logic [ist_pkg::WordW-1:0]   rd_q, rd_d;

  logic [XW-1:0] posx, cntx, paddrx;
  logic [CW-1:0] pos_cw, pos_inc, idx_inc, paddr_inc, paddr_dec;
  logic          full, pos_in, hit;

  logic                      we, re;
  logic [AW-1:0]             waddr, raddr;
  logic [ist_pkg::WordW-1:0] wdata, rdata;

  assign req_kind  = ist_pkg::kind_e'(req_i.kind);
  assign posx      = {{(XW-ist_pkg::PosW){1'b0}}, req_i.position};
  assign cntx      = {{(XW-CW){1'b0}}, count_q};
  assign paddrx    = {{(XW-CW){1'b0}}, paddr_q};
  assign pos_cw    = posx[CW-1:0];
  assign pos_inc   = pos_cw + OneC;
  assign idx_inc   = idx_q + OneC;
  assign paddr_inc = paddr_q + OneC;
  assign paddr_dec = paddr_q - OneC;
  assign full      = (count_q == CW'(Capacity));
  assign pos_in    = (posx < cntx);
  assign hit       = (rdata == value_q);

  ist_ram #(
    .Depth (Capacity),
    .AddrW (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ist_pkg::ST_IDLE;
      count_q <= '0;
      issue_q <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      issue_q <= issue_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    value_q <= value_d;
    pos_q   <= pos_d;
    idx_q   <= idx_d;
    paddr_q <= paddr_d;
    ok_q    <= ok_d;
    found_q <= found_d;
    rd_q    <= rd_d;
  end

  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    value_d = value_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    paddr_d = paddr_q;
    count_d = count_q;
    issue_d = issue_q;
    pend_d  = pend_q;
    ok_d    = ok_q;
    found_d = found_q;
    rd_d    = rd_q;
    we      = 1'b0;
    waddr   = count_q[AW-1:0];
    wdata   = req_i.value;
    re      = 1'b0;
    raddr   = idx_q[AW-1:0];
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    unique case (state_q)
      ist_pkg::ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          kind_d  = req_kind;
          value_d = req_i.value;
          pos_d   = pos_cw;
          ok_d    = 1'b0;
          found_d = '1;
          rd_d    = '1;
          pend_d  = 1'b0;
          issue_d = 1'b0;
          state_d = ist_pkg::ST_DONE;
          unique case (req_kind)
            ist_pkg::KIND_APPEND: begin
              if (!full) begin
                we      = 1'b1;
                count_d = count_q + OneC;
                ok_d    = 1'b1;
              end
            end
            ist_pkg::KIND_INSERT: begin
              if (pos_in && !full) begin
                idx_d   = count_q - OneC;
                issue_d = 1'b1;
                state_d = ist_pkg::ST_SCAN;
              end
            end
            ist_pkg::KIND_REMOVE: begin
              if (pos_in) begin
                idx_d   = pos_inc;
                issue_d = (pos_inc < count_q);
                state_d = ist_pkg::ST_SCAN;
              end
            end
            ist_pkg::KIND_FIND: begin
              idx_d   = '0;
              issue_d = (count_q != '0);
              state_d = ist_pkg::ST_SCAN;
            end
            ist_pkg::KIND_GET: begin
              if (pos_in) begin
                idx_d   = pos_cw;
                issue_d = 1'b1;
                state_d = ist_pkg::ST_SCAN;
              end
            end
            default: ;
          endcase
        end
      end
      ist_pkg::ST_SCAN: begin
        re = issue_q;
        if (issue_q) begin
          pend_d  = 1'b1;
          paddr_d = idx_q;
          unique case (kind_q)
            ist_pkg::KIND_INSERT: begin
              idx_d   = idx_q - OneC;
              issue_d = (idx_q != pos_q);
            end
            ist_pkg::KIND_GET: begin
              issue_d = 1'b0;
            end
            default: begin
              idx_d   = idx_inc;
              issue_d = (idx_inc < count_q);
            end
          endcase
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          unique case (kind_q)
            ist_pkg::KIND_INSERT: begin
              we    = 1'b1;
              waddr = paddr_inc[AW-1:0];
              wdata = rdata;
            end
            ist_pkg::KIND_REMOVE: begin
              we    = 1'b1;
              waddr = paddr_dec[AW-1:0];
              wdata = rdata;
            end
            ist_pkg::KIND_FIND: begin
              if (hit) begin
                ok_d    = 1'b1;
                found_d = paddrx[ist_pkg::OutPosW-1:0];
                issue_d = 1'b0;
                pend_d  = 1'b0;
                state_d = ist_pkg::ST_DONE;
              end
            end
            ist_pkg::KIND_GET: begin
              ok_d    = 1'b1;
              rd_d    = rdata;
              pend_d  = 1'b0;
              state_d = ist_pkg::ST_DONE;
            end
            default: ;
          endcase
        end
        if (!issue_q && !pend_q) begin
          state_d = ist_pkg::ST_DONE;
          unique case (kind_q)
            ist_pkg::KIND_INSERT: begin
              we      = 1'b1;
              waddr   = pos_q[AW-1:0];
              wdata   = value_q;
              count_d = count_q + OneC;
              ok_d    = 1'b1;
            end
            ist_pkg::KIND_REMOVE: begin
              count_d = count_q - OneC;
              ok_d    = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ist_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ist_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ist_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_o.ok             = ok_q;
  assign res_o.found_position = found_q;
  assign res_o.read_value     = rd_q;
  assign res_o.count          = cntx[ist_pkg::OutCntW-1:0];

endmodule

>>> rtl/core/indexed_sequence_table.sv
// indexed sequence table top level with output register
//
// channel   dir  beat fields (lsb first)
// s_axis    in   kind[2:0] value[34:3] position[38:35]
// m_axis    out  ok[0] found_position[5:1] read_value[37:6] count[42:38]
//
// append, unused kinds and refused insert, remove, get: no store read before the result
// get: one read; find: reads from entry 0 up to a match, none on an empty table
// insert: moves position..last up one; remove: moves the rest down, none for the last
// scans read one store word a cycle feeding one compare
// reset clears the count; stored words are undefined until written
// s_axis_tready is low from accept until the result moves to the output register
module indexed_sequence_table #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // kind, value, position
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // ok, found_position, read_value, count
);

  ist_pkg::req_t req;
  ist_pkg::res_t res, out_res_q;
  logic          res_valid, res_ready;
  logic          out_valid_q, out_valid_d;

  assign req.kind     = s_axis_tdata[2:0];
  assign req.value    = s_axis_tdata[34:3];
  assign req.position = s_axis_tdata[38:35];

  ist_seq #(
    .Capacity (CAPACITY)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_res_q};

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a request is in flight");

  a_fail_read_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[37:6] == 32'hffff_ffff))
    else $error("failed request carries a read value");

  a_fail_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[5:1] == 5'h1f))
    else $error("failed request carries a found position");
`endif

endmodule

>>> dv/indexed_sequence_table_test.sv
// self-checking stream testbench for the indexed sequence table
`timescale 1ns / 100ps

module indexed_sequence_table_test;

  localparam int unsigned Capacity = 16;
  localparam int unsigned RandomRequests = 500;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxReported = 10;
  localparam logic [ist_pkg::KindW-1:0] KindSpareFirst = 3'd5;
  localparam logic [ist_pkg::KindW-1:0] KindSpareMid = 3'd6;
  localparam logic [ist_pkg::KindW-1:0] KindSpareLast = 3'd7;
  localparam logic [ist_pkg::WordW-1:0] WordMin = 32'h8000_0000;
  localparam logic [ist_pkg::WordW-1:0] WordMax = 32'h7fff_ffff;
  localparam logic [ist_pkg::WordW-1:0] WordAllOnes = 32'hffff_ffff;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // kind, value, position, zero pad
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // ok, found_position, read_value, count, zero pad

  logic [ist_pkg::WordW-1:0] store_words [Capacity];
  int store_count;
  ist_pkg::res_t pending_results [$];
  bit quiet;
  int stall_left;
  int error_count;
  int results_checked;
  int requests_sent;
  int full_reached;
  int kind_hits [8];
  int cycle_count;

  indexed_sequence_table #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("indexed_sequence_table_test: errors");
      $finish;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // updates the table copy and returns the result for one request
  function automatic ist_pkg::res_t apply_request(
      input logic [ist_pkg::KindW-1:0] kind,
      input logic [ist_pkg::WordW-1:0] val,
      input logic [ist_pkg::PosW-1:0]  pos);
    ist_pkg::res_t res;
    int i;
    res.ok = 1'b0;
    res.found_position = '1;
    res.read_value = '1;
    case (kind)
      ist_pkg::KIND_APPEND: begin
        if (store_count < Capacity) begin
          store_words[store_count] = val;
          store_count++;
          res.ok = 1'b1;
        end
      end
      ist_pkg::KIND_INSERT: begin
        if (int'(pos) < store_count && store_count < Capacity) begin
          for (i = store_count; i > int'(pos); i--) store_words[i] = store_words[i-1];
          store_words[pos] = val;
          store_count++;
          res.ok = 1'b1;
        end
      end
      ist_pkg::KIND_REMOVE: begin
        if (int'(pos) < store_count) begin
          for (i = int'(pos); i + 1 < store_count; i++) store_words[i] = store_words[i+1];
          store_count--;
          res.ok = 1'b1;
        end
      end
      ist_pkg::KIND_FIND: begin
        for (i = 0; i < store_count; i++) begin
          if (!res.ok && store_words[i] == val) begin
            res.found_position = i[ist_pkg::OutPosW-1:0];
            res.ok = 1'b1;
          end
        end
      end
      ist_pkg::KIND_GET: begin
        if (int'(pos) < store_count) begin
          res.read_value = store_words[pos];
          res.ok = 1'b1;
        end
      end
      default: ;
    endcase
    res.count = store_count[ist_pkg::OutCntW-1:0];
    if (store_count == Capacity) full_reached++;
    return res;
  endfunction

  task automatic send_request(input logic [ist_pkg::KindW-1:0] kind,
                              input logic [ist_pkg::WordW-1:0] val,
                              input logic [ist_pkg::PosW-1:0]  pos);
    int gap;
    ist_pkg::req_t req;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.kind = kind;
    req.value = val;
    req.position = pos;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, req};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_request(kind, val, pos));
    kind_hits[kind]++;
    requests_sent++;
  endtask

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 3) == 0) begin
      m_axis_tready <= 1'b0;
      stall_left = pick_gap();
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    ist_pkg::res_t got;
    ist_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[$bits(ist_pkg::res_t)-1:0];
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MaxReported)
          $display("unexpected result beat: ok %0b pos %0d value %0d count %0d",
                   got.ok, got.found_position, got.read_value, got.count);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.ok !== want.ok || got.found_position !== want.found_position ||
            got.read_value !== want.read_value || got.count !== want.count) begin
          error_count++;
          if (error_count <= MaxReported) begin
            $display("result %0d: expected ok %0b pos %0d value %0d count %0d",
                     results_checked, want.ok, want.found_position, want.read_value,
                     want.count);
            $display("  got ok %0b pos %0d value %0d count %0d",
                     got.ok, got.found_position, got.read_value, got.count);
          end
        end
      end
    end
  end

  function automatic logic [ist_pkg::WordW-1:0] pick_value();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 2) return ist_pkg::WordW'($urandom_range(0, 4)) - 32'd2;
    if (roll == 2) begin
      case ($urandom_range(0, 3))
        0: return WordMin;
        1: return WordMax;
        2: return '0;
        default: return WordAllOnes;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [ist_pkg::PosW-1:0] pick_position();
    if (store_count > 0 && $urandom_range(0, 4) != 0)
      return ist_pkg::PosW'($urandom_range(0, store_count - 1));
    return ist_pkg::PosW'($urandom_range(0, Capacity - 1));
  endfunction

  task automatic test_empty_table();
    send_request(ist_pkg::KIND_FIND, '0, '0);
    send_request(ist_pkg::KIND_GET, WordAllOnes, '0);
    send_request(ist_pkg::KIND_INSERT, WordMax, '0);
    send_request(ist_pkg::KIND_REMOVE, '0, '0);
    send_request(KindSpareLast, WordAllOnes, '1);
  endtask

  task automatic test_fill_to_full();
    int i;
    for (i = 0; i < Capacity; i++) begin
      if (i == 0) send_request(ist_pkg::KIND_APPEND, WordMin, '0);
      else if (i == Capacity - 1) send_request(ist_pkg::KIND_APPEND, WordMax, '0);
      else send_request(ist_pkg::KIND_APPEND, ist_pkg::WordW'(i * 32'h1111_1111),
                        ist_pkg::PosW'(i));
    end
    send_request(ist_pkg::KIND_APPEND, 32'd7, '0);
    send_request(ist_pkg::KIND_INSERT, 32'd7, 4'd3);
    send_request(ist_pkg::KIND_GET, '0, '1);
    send_request(ist_pkg::KIND_FIND, WordMin, '0);
  endtask

  task automatic test_edit_positions();
    send_request(ist_pkg::KIND_REMOVE, '0, '1);
    send_request(ist_pkg::KIND_GET, '0, '1);
    send_request(ist_pkg::KIND_INSERT, WordAllOnes, '0);
    send_request(ist_pkg::KIND_FIND, WordAllOnes, '0);
    send_request(ist_pkg::KIND_REMOVE, '0, '0);
    send_request(KindSpareFirst, '0, '0);
  endtask

  // mostly well-formed edits; the table drifts between empty and full
  task automatic test_random_sequences();
    int done;
    int roll;
    bit grow;
    logic [ist_pkg::KindW-1:0] kind;
    logic [ist_pkg::WordW-1:0] val;
    done = 0;
    grow = 1'b1;
    while (done < RandomRequests) begin
      quiet = ((done / 25) % 4) == 3;
      if (store_count == Capacity) grow = 1'b0;
      else if (store_count == 0) grow = 1'b1;
      else if ($urandom_range(0, 29) == 0) grow = !grow;
      roll = $urandom_range(0, 99);
      if (roll < 3) kind = KindSpareFirst + ist_pkg::KindW'($urandom_range(0, 2));
      else if (roll < 43) kind = grow ? ist_pkg::KIND_APPEND : ist_pkg::KIND_REMOVE;
      else if (roll < 68) kind = grow ? ist_pkg::KIND_INSERT : ist_pkg::KIND_REMOVE;
      else if (roll < 78) kind = grow ? ist_pkg::KIND_REMOVE : ist_pkg::KIND_INSERT;
      else if (roll < 92) kind = ist_pkg::KIND_FIND;
      else kind = ist_pkg::KIND_GET;
      if (kind == ist_pkg::KIND_FIND && store_count > 0 && $urandom_range(0, 2) != 0)
        val = store_words[$urandom_range(0, store_count - 1)];
      else
        val = pick_value();
      send_request(kind, val, pick_position());
      if (kind <= ist_pkg::KIND_GET) done++;
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_fill_to_full();
    test_edit_positions();
    test_random_sequences();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4 * Capacity) @(posedge clk_i);
    if (pending_results.size() != 0) error_count++;
    $display("%0d requests, %0d results checked, %0d requests left the table full",
             requests_sent, results_checked, full_reached);
    $display("by kind: append %0d insert %0d remove %0d find %0d get %0d unused %0d",
             kind_hits[ist_pkg::KIND_APPEND], kind_hits[ist_pkg::KIND_INSERT],
             kind_hits[ist_pkg::KIND_REMOVE], kind_hits[ist_pkg::KIND_FIND],
             kind_hits[ist_pkg::KIND_GET],
             kind_hits[KindSpareFirst] + kind_hits[KindSpareMid] + kind_hits[KindSpareLast]);
    if (error_count == 0) begin
      $display("indexed_sequence_table_test: clean");
    end else begin
      $display("indexed_sequence_table_test: errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/ist_pkg.sv
rtl/core/ist_ram.sv
rtl/core/ist_seq.sv
rtl/core/indexed_sequence_table.sv
dv/indexed_sequence_table_test.sv
